[hw/rtl/dwc_pkg.sv]
package dwc_pkg;

    localparam logic [2:0] CMD_WEIGHT    = 3'd0;
    localparam logic [2:0] CMD_IN_SCALE  = 3'd1;
    localparam logic [2:0] CMD_BIAS      = 3'd2;
    localparam logic [2:0] CMD_OUT_SCALE = 3'd3;
    localparam logic [2:0] CMD_PIXEL     = 3'd4;

    localparam logic [2:0] REG_ROW_WIDTH     = 3'd0;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_DILATION_X    = 3'd3;
    localparam logic [2:0] REG_DILATION_Y    = 3'd4;
    localparam logic [2:0] REG_STRIDE_X      = 3'd5;
    localparam logic [2:0] REG_STRIDE_Y      = 3'd6;
    localparam logic [2:0] REG_REQUANTIZE    = 3'd7;

    localparam int CFG_W = 11;

    localparam int MAX_KERNEL   = 7;
    localparam int MAX_DILATION = 4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         tap_index;
        logic signed [31:0] value;
        logic               channel_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [9:0]         out_col;
        logic [9:0]         out_row;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic       busy;
        logic [2:0] remainder;
    } div_status_t;

endpackage

[hw/rtl/dwc_div.sv]
module dwc_div
    import dwc_pkg::*;
#(
    parameter int W = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [2:0]   divisor,
    output logic [W-1:0] quotient,
    output div_status_t  status
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     dq_reg;
    logic [2:0]       rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [3:0]       trial;
    logic             ge;
    logic [2:0]       rem_next;

    assign trial    = {rem_reg, dq_reg[W-1]};
    assign ge       = trial >= {1'b0, divisor};
    assign rem_next = ge ? 3'(trial - {1'b0, divisor}) : trial[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient         = dq_reg;
    assign status.busy      = busy_reg;
    assign status.remainder = rem_reg;

endmodule

[hw/rtl/depthwise_conv_int8_requant.sv]
// Int8 depthwise convolution of one channel with optional requantization.
// Load items and pixels that complete no window leave the block idle. A
// pixel that completes a window starts the stride dividers; when the window
// is not stride aligned it ends there. An aligned window then walks one
// kernel tap per cycle through the shared multiply-accumulate that reads the
// line store and the weight memory, then drains, applies the input scale,
// rounding and bias, and, when requantizing, the output scale and rounding,
// and loads the output register, which waits while a held output transfer is
// pending. The line store and weight memory are not cleared at reset.
module depthwise_conv_int8_requant
    import dwc_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int LINE_ROWS  = MAX_DILATION * (MAX_KERNEL - 1) + 1;
    localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
    localparam int MAX_TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RWW        = $clog2(MAX_WIDTH + 1);
    localparam int SW         = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int TW         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int DW         = (CW > 10) ? CW : 10;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_MAC   = 10'b0000000100,
        S_DRAIN = 10'b0000001000,
        S_MUL1  = 10'b0000010000,
        S_RND1  = 10'b0000100000,
        S_BIAS  = 10'b0001000000,
        S_MUL2  = 10'b0010000000,
        S_RND2  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] row_width_reg;
    logic [2:0] kernel_width_reg, kernel_height_reg;
    logic [2:0] dilation_x_reg, dilation_y_reg, stride_x_reg, stride_y_reg;
    logic       requantize_reg;

    logic signed [31:0] in_scale_reg, bias_reg, out_scale_reg;
    logic [CW-1:0] col_pos_reg;
    logic [9:0]    row_pos_reg;
    logic [SW-1:0] ring_reg;

    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] wt_mem [MAX_TAPS];
    logic [7:0] pix_rd_reg, wt_rd_reg;
    logic       rd_valid_reg;

    logic [CW-1:0] x0_reg, c_reg;
    logic [SW-1:0] win_ring_reg;
    logic          end_reg;
    logic [SW-1:0] slot_reg;
    logic [2:0]    kx_reg, ky_reg;
    logic [TW-1:0] t_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] prod_reg, rnd_reg;
    logic signed [31:0] res_reg;
    logic          out_valid_reg;
    out_item_t     out_data_reg;

    logic [RWW-1:0] rw;
    logic [2:0] kw, kh, dx, dy, sx, sy;
    logic [7:0] ew, eh;

    always_comb
    begin
        if (row_width_reg == '0)
            rw = RWW'(1);
        else if (32'(row_width_reg) > 32'(MAX_WIDTH))
            rw = RWW'(MAX_WIDTH);
        else
            rw = RWW'(row_width_reg);
        if (kernel_width_reg == '0)
            kw = 3'd1;
        else if (32'(kernel_width_reg) > 32'(MAX_KERNEL))
            kw = 3'(MAX_KERNEL);
        else
            kw = kernel_width_reg;
        if (kernel_height_reg == '0)
            kh = 3'd1;
        else if (32'(kernel_height_reg) > 32'(MAX_KERNEL))
            kh = 3'(MAX_KERNEL);
        else
            kh = kernel_height_reg;
        if (dilation_x_reg == '0)
            dx = 3'd1;
        else if (32'(dilation_x_reg) > 32'(MAX_DILATION))
            dx = 3'(MAX_DILATION);
        else
            dx = dilation_x_reg;
        if (dilation_y_reg == '0)
            dy = 3'd1;
        else if (32'(dilation_y_reg) > 32'(MAX_DILATION))
            dy = 3'(MAX_DILATION);
        else
            dy = dilation_y_reg;
        sx = (stride_x_reg == '0) ? 3'd1 : stride_x_reg;
        sy = (stride_y_reg == '0) ? 3'd1 : stride_y_reg;
        ew = 8'(8'(dx) * 8'(kw - 3'd1)) + 8'd1;
        eh = 8'(8'(dy) * 8'(kh - 3'd1)) + 8'd1;
    end

    logic          accept, pix_accept, wrap;
    logic [CW-1:0] col;
    logic [9:0]    row;
    logic [SW-1:0] ring;
    logic [SW:0]   ring_inc;
    logic          window;
    logic [15:0]   col1, row1;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign pix_accept = accept && (in_data.cmd == CMD_PIXEL);

    always_comb
    begin
        wrap     = RWW'(col_pos_reg) >= rw;
        ring_inc = {1'b0, ring_reg} + 1'b1;
        if (ring_inc >= (SW + 1)'(LINE_ROWS))
            ring_inc = '0;
        col  = wrap ? '0 : col_pos_reg;
        row  = wrap ? 10'(row_pos_reg + 1'b1) : row_pos_reg;
        ring = wrap ? ring_inc[SW-1:0] : ring_reg;
        col1 = 16'(col) + 16'd1;
        row1 = 16'(row) + 16'd1;
        window = (col1 >= 16'(ew)) && (row1 >= 16'(eh));
    end

    logic [SW:0] ring_step;

    always_comb
    begin
        ring_step = {1'b0, ring} + 1'b1;
        if (ring_step >= (SW + 1)'(LINE_ROWS))
            ring_step = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg     <= CFG_W'(1);
            kernel_width_reg  <= 3'd3;
            kernel_height_reg <= 3'd3;
            dilation_x_reg    <= 3'd1;
            dilation_y_reg    <= 3'd1;
            stride_x_reg      <= 3'd1;
            stride_y_reg      <= 3'd1;
            requantize_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:     row_width_reg     <= cfg_data;
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[2:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[2:0];
                REG_DILATION_X:    dilation_x_reg    <= cfg_data[2:0];
                REG_DILATION_Y:    dilation_y_reg    <= cfg_data[2:0];
                REG_STRIDE_X:      stride_x_reg      <= cfg_data[2:0];
                REG_STRIDE_Y:      stride_y_reg      <= cfg_data[2:0];
                REG_REQUANTIZE:    requantize_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_scale_reg  <= '0;
            bias_reg      <= '0;
            out_scale_reg <= '0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            ring_reg      <= '0;
        end
        else if (accept)
        begin
            case (in_data.cmd)
                CMD_IN_SCALE:  in_scale_reg  <= in_data.value;
                CMD_BIAS:      bias_reg      <= in_data.value;
                CMD_OUT_SCALE: out_scale_reg <= in_data.value;
                CMD_PIXEL:
                begin
                    if (in_data.channel_end)
                    begin
                        col_pos_reg <= '0;
                        row_pos_reg <= '0;
                        ring_reg    <= '0;
                    end
                    else if (RWW'(col1) >= rw)
                    begin
                        col_pos_reg <= '0;
                        row_pos_reg <= 10'(row + 1'b1);
                        ring_reg    <= ring_step[SW-1:0];
                    end
                    else
                    begin
                        col_pos_reg <= CW'(col1);
                        row_pos_reg <= row;
                        ring_reg    <= ring;
                    end
                end
                default: ;
            endcase
        end
    end

    logic          line_re, wt_we;
    logic [AW-1:0] waddr, raddr;
    logic [TW-1:0] wt_waddr;

    assign waddr    = AW'(AW'(ring) * AW'(MAX_WIDTH)) + AW'(col);
    assign raddr    = AW'(AW'(slot_reg) * AW'(MAX_WIDTH)) + AW'(c_reg);
    assign line_re  = (state_reg == S_MAC);
    assign wt_waddr = TW'(32'(in_data.tap_index));
    assign wt_we    = accept && (in_data.cmd == CMD_WEIGHT)
                      && (32'(in_data.tap_index) < 32'(MAX_TAPS));

    always_ff @(posedge clk)
    begin
        if (pix_accept)
            line_mem[waddr] <= in_data.value[7:0];
        if (line_re)
            pix_rd_reg <= line_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_waddr] <= in_data.value[7:0];
        if (line_re)
            wt_rd_reg <= wt_mem[t_reg];
    end

    logic [DW-1:0] qx, qy;
    div_status_t   dsx, dsy;
    logic          div_start;
    logic [15:0]   x0_full, y0_full;

    assign x0_full   = col1 - 16'(ew);
    assign y0_full   = row1 - 16'(eh);
    assign div_start = pix_accept && window;

    dwc_div #(.W(DW)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(x0_full[CW-1:0])),
        .divisor  (sx),
        .quotient (qx),
        .status   (dsx)
    );

    dwc_div #(.W(DW)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(y0_full[9:0])),
        .divisor  (sy),
        .quotient (qy),
        .status   (dsy)
    );

    logic [SW:0]   slot_start, slot_adv;
    logic [SW+8:0] slot_sum;

    always_comb
    begin
        slot_sum = (SW + 9)'(win_ring_reg) + (SW + 9)'(LINE_ROWS) - (SW + 9)'(eh - 8'd1);
        if (slot_sum >= (SW + 9)'(LINE_ROWS))
            slot_sum = slot_sum - (SW + 9)'(LINE_ROWS);
        slot_start = slot_sum[SW:0];
        slot_adv   = {1'b0, slot_reg} + (SW + 1)'(dy);
        if (slot_adv >= (SW + 1)'(LINE_ROWS))
            slot_adv = slot_adv - (SW + 1)'(LINE_ROWS);
    end

    logic signed [15:0] tap_prod;
    logic signed [63:0] mul_in_a, mul_in_b, mul_out;
    logic signed [63:0] rnd8, rnd40, biased;

    assign tap_prod = $signed(pix_rd_reg) * $signed(wt_rd_reg);
    assign mul_in_a = (state_reg == S_MUL1) ? 64'(acc_reg) : 64'(res_reg);
    assign mul_in_b = (state_reg == S_MUL1) ? 64'(in_scale_reg) : 64'(out_scale_reg);
    assign mul_out  = mul_in_a * mul_in_b;
    // Rounding half away from zero: a negative value takes one less before the shift.
    assign rnd8     = (prod_reg + (prod_reg[63] ? 64'sd127 : 64'sd128)) >>> 8;
    assign rnd40    = (prod_reg + (prod_reg[63] ? 64'sh7F_FFFF_FFFF : 64'sh80_0000_0000))
                      >>> 40;
    assign biased   = rnd_reg + 64'(bias_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (div_start)
                    state_next = S_DIV;
            S_DIV:
                if (!dsx.busy && !dsy.busy)
                begin
                    if (dsx.remainder == '0 && dsy.remainder == '0)
                        state_next = S_MAC;
                    else
                        state_next = S_IDLE;
                end
            S_MAC:
                if (kx_reg == kw - 3'd1 && ky_reg == kh - 3'd1)
                    state_next = S_DRAIN;
            S_DRAIN: state_next = S_MUL1;
            S_MUL1:  state_next = S_RND1;
            S_RND1:  state_next = S_BIAS;
            S_BIAS:  state_next = requantize_reg ? S_MUL2 : S_OUT;
            S_MUL2:  state_next = S_RND2;
            S_RND2:  state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= line_re;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            x0_reg       <= x0_full[CW-1:0];
            win_ring_reg <= ring;
            end_reg      <= in_data.channel_end;
        end
        if (state_reg == S_DIV)
        begin
            slot_reg <= slot_start[SW-1:0];
            c_reg    <= x0_reg;
            kx_reg   <= '0;
            ky_reg   <= '0;
            t_reg    <= '0;
            acc_reg  <= '0;
        end
        if (state_reg == S_MAC)
        begin
            t_reg <= t_reg + 1'b1;
            if (kx_reg == kw - 3'd1)
            begin
                kx_reg   <= '0;
                c_reg    <= x0_reg;
                ky_reg   <= ky_reg + 1'b1;
                slot_reg <= slot_adv[SW-1:0];
            end
            else
            begin
                kx_reg <= kx_reg + 1'b1;
                c_reg  <= c_reg + CW'(dx);
            end
        end
        if (rd_valid_reg)
            acc_reg <= acc_reg + 32'(tap_prod);
        if (state_reg == S_MUL1 || state_reg == S_MUL2)
            prod_reg <= mul_out;
        if (state_reg == S_RND1)
            rnd_reg <= rnd8;
        if (state_reg == S_BIAS)
        begin
            if (biased > 64'sh7FFF_FFFF)
                res_reg <= 32'sh7FFF_FFFF;
            else if (biased < -64'sh8000_0000)
                res_reg <= -32'sh8000_0000;
            else
                res_reg <= 32'(biased);
        end
        if (state_reg == S_RND2)
        begin
            if (rnd40 > 64'sd127)
                res_reg <= 32'sd127;
            else if (rnd40 < -64'sd127)
                res_reg <= -32'sd127;
            else
                res_reg <= 32'(rnd40);
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            out_data_reg.result_value <= res_reg;
            out_data_reg.out_col      <= qx[9:0];
            out_data_reg.out_row      <= qy[9:0];
            out_data_reg.last         <= end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_read_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_MAC))
        else $error("tap data arrived without a read issue");

    a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ring_reg) < 32'(LINE_ROWS))
        else $error("ring row pointer out of range");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> state_reg == S_OUT)
        else $error("result overwrote a pending transfer");

    a_div_done_before_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> !dsx.busy && !dsy.busy)
        else $error("taps walked while the stride divider was busy");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import dwc_pkg::*;
();

    localparam int LINE_ROWS = 25;
    localparam int ROW_MAX = 1024;
    localparam int SETTLE_CYCLES = 200;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    depthwise_conv_int8_requant u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    in_item_t  pending_items[$];
    out_item_t conv_results[$];

    logic [7:0]  line_mem[LINE_ROWS*ROW_MAX];
    logic [7:0]  tap_mem[49];
    logic [10:0] r_row_width;
    logic [2:0]  r_kw, r_kh, r_dx, r_dy, r_sx, r_sy;
    logic        r_requant;
    logic [31:0] s_in_scale, s_bias, s_out_scale;
    int          col_pos, row_pos, ring_row;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    bit  took_item;
    int  mismatches;
    int  results_seen;
    int  items_sent;
    bit  failed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_shift(longint x, int sh);
        longint mag;
        longint r;
        mag = x < 0 ? -x : x;
        r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return x < 0 ? -r : r;
    endfunction

    function automatic void advance_row();
        col_pos = 0;
        row_pos = (row_pos + 1) & 1023;
        ring_row = (ring_row + 1) % LINE_ROWS;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [CFG_W-1:0] v);
        case (idx)
            REG_ROW_WIDTH:     r_row_width = v;
            REG_KERNEL_WIDTH:  r_kw = v[2:0];
            REG_KERNEL_HEIGHT: r_kh = v[2:0];
            REG_DILATION_X:    r_dx = v[2:0];
            REG_DILATION_Y:    r_dy = v[2:0];
            REG_STRIDE_X:      r_sx = v[2:0];
            REG_STRIDE_Y:      r_sy = v[2:0];
            REG_REQUANTIZE:    r_requant = v[0];
            default: ;
        endcase
    endfunction

    function automatic void convolve_pixel(in_item_t it);
        int rw, kw, kh, dx, dy, sx, sy, ew, eh, col, row, x0, y0, slot, acc;
        longint q16, res;
        out_item_t o;
        case (it.cmd)
            CMD_WEIGHT:    if (it.tap_index < 49) tap_mem[it.tap_index] = it.value[7:0];
            CMD_IN_SCALE:  s_in_scale = it.value;
            CMD_BIAS:      s_bias = it.value;
            CMD_OUT_SCALE: s_out_scale = it.value;
            default: ;
        endcase
        if (it.cmd != CMD_PIXEL)
            return;
        rw = clamp_int(r_row_width, 1, ROW_MAX);
        kw = clamp_int(r_kw, 1, 7);
        kh = clamp_int(r_kh, 1, 7);
        dx = clamp_int(r_dx, 1, 4);
        dy = clamp_int(r_dy, 1, 4);
        sx = clamp_int(r_sx, 1, 7);
        sy = clamp_int(r_sy, 1, 7);
        ew = dx * (kw - 1) + 1;
        eh = dy * (kh - 1) + 1;
        if (col_pos >= rw)
            advance_row();
        col = col_pos;
        row = row_pos;
        line_mem[ring_row*ROW_MAX + col] = it.value[7:0];
        if (col + 1 >= ew && row + 1 >= eh)
        begin
            x0 = col + 1 - ew;
            y0 = row + 1 - eh;
            if (x0 % sx == 0 && y0 % sy == 0)
            begin
                acc = 0;
                for (int ky = 0; ky < kh; ky++)
                begin
                    slot = (ring_row + LINE_ROWS - ((eh - 1) - ky*dy)) % LINE_ROWS;
                    for (int kx = 0; kx < kw; kx++)
                        acc += int'($signed(line_mem[slot*ROW_MAX + x0 + kx*dx]))
                             * int'($signed(tap_mem[ky*kw + kx]));
                end
                q16 = round_shift(longint'(acc) * longint'($signed(s_in_scale)), 8)
                    + longint'($signed(s_bias));
                q16 = q16 > 64'sd2147483647 ? 64'sd2147483647 : q16;
                q16 = q16 < -64'sd2147483648 ? -64'sd2147483648 : q16;
                if (r_requant)
                begin
                    res = round_shift(q16 * longint'($signed(s_out_scale)), 40);
                    res = res > 127 ? 127 : (res < -127 ? -127 : res);
                end
                else
                    res = q16;
                o.result_value = res[31:0];
                o.out_col = 10'(x0 / sx);
                o.out_row = 10'(y0 / sy);
                o.last = it.channel_end;
                conv_results.push_back(o);
            end
        end
        if (it.channel_end)
        begin
            col_pos = 0;
            row_pos = 0;
            ring_row = 0;
        end
        else if (col + 1 >= rw)
            advance_row();
        else
            col_pos = col + 1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            took_item = in_valid && !in_stall;
            if (took_item)
                convolve_pixel(in_data);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (conv_results.size() == 0)
                begin
                    failed = 1'b1;
                    $display("unexpected result transfer: %p", out_data);
                end
                else if (conv_results[0] !== out_data)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", conv_results[0], out_data);
                    void'(conv_results.pop_front());
                end
                else
                    void'(conv_results.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took_item))
        begin
            if (pending_items.size() == 0 || $urandom_range(0, 99) < send_idle_pct)
                in_valid <= 1'b0;
            else
            begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
                items_sent++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || conv_results.size() != 0
               || hold_cycles != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int rw, int kw, int kh, int dx, int dy, int sx, int sy, int rq);
        wait_drained();
        write_reg(REG_ROW_WIDTH, rw);
        write_reg(REG_KERNEL_WIDTH, kw);
        write_reg(REG_KERNEL_HEIGHT, kh);
        write_reg(REG_DILATION_X, dx);
        write_reg(REG_DILATION_Y, dy);
        write_reg(REG_STRIDE_X, sx);
        write_reg(REG_STRIDE_Y, sy);
        write_reg(REG_REQUANTIZE, rq);
    endtask

    function automatic void push_item(logic [2:0] cmd, int tap, logic [31:0] v, bit e);
        in_item_t it;
        it.cmd = cmd;
        it.tap_index = tap[5:0];
        it.value = v;
        it.channel_end = e;
        pending_items.push_back(it);
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0400_0000);
            2: return -$urandom_range(0, 32'h0400_0000);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic void load_channel_params(int n_taps);
        for (int t = 0; t < n_taps; t++)
            push_item(CMD_WEIGHT, t, $urandom(), $urandom_range(0, 9) == 0);
        push_item(CMD_IN_SCALE, $urandom_range(0, 63), pick_scale(), 1'b0);
        push_item(CMD_BIAS, $urandom_range(0, 63), $urandom(), 1'b0);
        push_item(CMD_OUT_SCALE, $urandom_range(0, 63), pick_scale(), 1'b0);
        if ($urandom_range(0, 3) == 0)
            push_item(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom(), 1'b1);
    endfunction

    function automatic void push_pixels(int n, bit with_end);
        for (int i = 0; i < n; i++)
            push_item(CMD_PIXEL, $urandom_range(0, 63), $urandom(),
                      with_end && i == n - 1);
    endfunction

    initial
    begin
        int kw, kh, dx, dy, rw, phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROW_WIDTH;
        cfg_data = '0;
        took_item = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        failed = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 77;
        r_row_width = 1; r_kw = 3; r_kh = 3;
        r_dx = 1; r_dy = 1; r_sx = 1; r_sy = 1; r_requant = 1'b0;
        s_in_scale = 0; s_bias = 0; s_out_scale = 0;
        col_pos = 0; row_pos = 0; ring_row = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme weights, ignored commands, zero scale, saturation,
        // and a final pixel whose window is not stride aligned.
        set_geometry(3, 2, 2, 1, 1, 2, 1, 1);
        push_item(CMD_WEIGHT, 0, 32'h7F, 1'b1);
        push_item(CMD_WEIGHT, 1, 32'hFFFF_FF80, 1'b0);
        push_item(CMD_WEIGHT, 2, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_WEIGHT, 3, 32'h0000_0001, 1'b0);
        push_item(CMD_WEIGHT, 63, 32'h55, 1'b0);
        push_item(3'd5, 0, 32'hFFFF_FFFF, 1'b1);
        push_item(3'd6, 63, 0, 1'b0);
        push_item(3'd7, 7, 32'h8000_0000, 1'b0);
        push_item(CMD_IN_SCALE, 0, 0, 1'b0);
        push_item(CMD_BIAS, 0, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_OUT_SCALE, 0, 32'h0100_0000, 1'b0);
        push_pixels(4, 1'b0);
        push_item(CMD_IN_SCALE, 0, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_BIAS, 0, 32'h8000_0000, 1'b0);
        push_item(CMD_PIXEL, 0, 32'h7F, 1'b0);
        push_item(CMD_PIXEL, 0, 32'hFFFF_FF80, 1'b0);
        push_item(CMD_PIXEL, 0, 32'h80, 1'b0);
        push_item(CMD_PIXEL, 0, 32'h7F, 1'b0);
        push_item(CMD_PIXEL, 0, 32'h01, 1'b1);

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase == 4)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 13;
            end
            if (phase == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kw = $urandom_range(1, 4);
            kh = $urandom_range(1, 4);
            dx = $urandom_range(1, 2);
            dy = $urandom_range(1, 2);
            rw = dx*(kw - 1) + 1 + $urandom_range(0, 3);
            set_geometry(rw, kw, kh, dx, dy, $urandom_range(1, 3),
                         $urandom_range(1, 3), $urandom_range(0, 1));
            load_channel_params(kw * kh);
            if (phase == 3)
            begin
                push_pixels(rw * (dy*(kh - 1) + 1), 1'b0);
                hold_cycles = 400;
                push_pixels(rw * 3, 1'b0);
                wait_drained();
                push_pixels(rw * 2, 1'b1);
            end
            else if (phase == 7)
            begin
                push_pixels(rw * (dy*(kh - 1) + 2) + rw - 1, 1'b0);
                wait_drained();
                write_reg(REG_ROW_WIDTH, dx*(kw - 1) + 1);
                push_pixels((dx*(kw - 1) + 1) * 4, 1'b1);
            end
            else
                push_pixels(rw * (dy*(kh - 1) + 1 + $urandom_range(0, 1))
                            + $urandom_range(0, rw - 1), 1'b1);
        end

        // Largest kernel, then clamped registers.
        set_geometry(7, 7, 7, 1, 1, 1, 1, 1);
        load_channel_params(49);
        push_pixels(7 * 8, 1'b1);
        set_geometry(5, 2, 0, 7, 0, 7, 7, 0);
        load_channel_params(2);
        push_pixels(5 * 8, 1'b1);
        set_geometry(0, 1, 1, 1, 1, 0, 1, 0);
        push_pixels(5, 1'b1);
        wait_drained();

        $display("Ran %0d item transfers and checked %0d result transfers over", items_sent,
                 results_seen);
        $display("random kernels and strides, a 7x7 kernel, clamped registers and long stalls.");
        if (!failed && mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
